FILE: rtl/scfl_pkg.sv
// shared types, constants and codes for the size-class free-list cache
package scfl_pkg;

  localparam int CLASSES     = 8;
  localparam int STACK_DEPTH = 16;
  localparam int WORD_BYTES  = 8;

  localparam int ADDR_W   = 48;
  localparam int SIZE_W   = 32;
  localparam int BSIZE_W  = 33;
  localparam int ZONE_W   = 6;
  localparam int EXP_W    = 6;
  localparam int SMALL_W  = 5;
  localparam int CAP_W    = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam int CLASS_W   = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int SLOT_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int COUNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int MEM_DEPTH = CLASSES * STACK_DEPTH;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMALLEST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAP      = 1'd1;

  localparam logic [SMALL_W-1:0] SMALLEST_RESET = 5'd3;
  localparam logic [CAP_W-1:0]   CAP_RESET      = 4'd15;

  // request kinds
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // outcome codes
  localparam logic [1:0] OUT_FROM_POOL   = 2'd0;
  localparam logic [1:0] OUT_FETCH       = 2'd1;
  localparam logic [1:0] OUT_KEPT        = 2'd2;
  localparam logic [1:0] OUT_GIVE_BACK   = 2'd3;

  typedef struct packed {
    logic              func;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic [ADDR_W-1:0]  result_address;
    logic [BSIZE_W-1:0] backing_size;
    logic [ZONE_W-1:0]  class_index;
    logic               bypassed;
  } resp_t;

  typedef struct packed {
    logic [EXP_W-1:0]  exponent;
    logic [ZONE_W-1:0] zone;
    logic              bypass;
  } class_info_t;

endpackage

FILE: rtl/scfl_classify.sv
// size to class mapping: ceiling log2, raise to the minimum, class offset
module scfl_classify (
  input  logic [scfl_pkg::SIZE_W-1:0]  size,
  input  logic [scfl_pkg::SMALL_W-1:0] smallest,
  output scfl_pkg::class_info_t        info
);

  logic [4:0]                  top;
  logic                        pow2;
  logic [scfl_pkg::EXP_W-1:0]  exp_raw;
  logic [scfl_pkg::EXP_W-1:0]  exp_raised;
  logic [scfl_pkg::EXP_W-1:0]  small_ext;

  // highest set bit
  always_comb begin
    top = 5'd0;
    for (int b = 0; b < scfl_pkg::SIZE_W; b++) begin
      if (size[b]) begin
        top = 5'(b);
      end
    end
  end

  assign pow2      = ((size & (size - 32'd1)) == '0);
  assign small_ext = {1'b0, smallest};

  always_comb begin
    if (size == '0) begin
      exp_raw = 6'd1;
    end else if (pow2) begin
      exp_raw = {1'b0, top};
    end else begin
      exp_raw = {1'b0, top} + 6'd1;
    end
    exp_raised    = (exp_raw < small_ext) ? small_ext : exp_raw;
    info.exponent = exp_raised;
    info.zone     = exp_raised - small_ext;
    info.bypass   = (info.zone >= scfl_pkg::ZONE_W'(scfl_pkg::CLASSES));
  end

endmodule

FILE: rtl/size_class_free_list_cache_unit.sv
// top level: per-class address stacks held in one synchronous slot memory
// accept in idle, then CALC (class lookup and slot access) and READ (slot read data
//   return), then the output register, where the result is held until taken; a new
//   request is accepted only in idle, once the previous result has been loaded
// reset: stack counts cleared, state, out_valid and configuration back to reset values;
//   slot memory is not cleared, so no clearing pass and no wait after reset
module size_class_free_list_cache_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  scfl_pkg::req_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output scfl_pkg::resp_t                   out_data,
  input  logic                              cfg_write,
  input  logic [scfl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scfl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // configuration
  logic [scfl_pkg::SMALL_W-1:0] smallest;
  logic [scfl_pkg::CAP_W-1:0]   list_cap;

  // request held for the lookup cycle
  scfl_pkg::req_t req;

  // per-class stack depths, in flops so reset clears them at once
  logic [scfl_pkg::COUNT_W-1:0] counts [scfl_pkg::CLASSES];

  // slot memory: one write port, one registered read port
  logic [scfl_pkg::ADDR_W-1:0] slots [scfl_pkg::MEM_DEPTH];
  logic [scfl_pkg::ADDR_W-1:0] rd_data;
  logic                        mem_we;
  logic                        mem_re;
  logic [scfl_pkg::MEM_AW-1:0] mem_idx;

  // response built in the lookup cycle, address patched from memory if popped
  scfl_pkg::resp_t pend;
  scfl_pkg::resp_t pend_next;
  scfl_pkg::resp_t pend_patched;
  logic            pop_hit;
  logic            pop_hit_next;

  scfl_pkg::class_info_t        info;
  logic [scfl_pkg::CLASS_W-1:0] cls;
  logic [scfl_pkg::COUNT_W-1:0] cnt;
  logic [scfl_pkg::COUNT_W-1:0] cnt_new;
  logic                         cnt_we;
  logic [scfl_pkg::COUNT_W-1:0] slot;
  logic [scfl_pkg::BSIZE_W-1:0] rounded;
  logic                         out_free;

  scfl_classify u_classify (
    .size     (req.request_size),
    .smallest (smallest),
    .info     (info)
  );

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign cls      = info.zone[scfl_pkg::CLASS_W-1:0];
  assign cnt      = counts[cls];

  // bypassed allocate rounds the size up to whole words
  assign rounded = ({1'b0, req.request_size} + scfl_pkg::BSIZE_W'(scfl_pkg::WORD_BYTES - 1))
                 & ~scfl_pkg::BSIZE_W'(scfl_pkg::WORD_BYTES - 1);

  // decision for the held request
  always_comb begin
    pend_next                = '0;
    pend_next.class_index    = info.zone;
    pend_next.bypassed       = info.bypass;
    pop_hit_next             = 1'b0;
    mem_we                   = 1'b0;
    mem_re                   = 1'b0;
    cnt_we                   = 1'b0;
    cnt_new                  = cnt;
    slot                     = cnt;
    if (info.bypass) begin
      if (req.func == scfl_pkg::FUNC_ALLOC) begin
        pend_next.outcome      = scfl_pkg::OUT_FETCH;
        pend_next.backing_size = rounded;
      end else begin
        pend_next.outcome        = scfl_pkg::OUT_GIVE_BACK;
        pend_next.result_address = req.block_address;
      end
    end else if (req.func == scfl_pkg::FUNC_ALLOC) begin
      if (cnt == '0) begin
        // empty stack: ask backing for the whole class size
        pend_next.outcome      = scfl_pkg::OUT_FETCH;
        pend_next.backing_size = scfl_pkg::BSIZE_W'(1) << info.exponent;
      end else begin
        pend_next.outcome = scfl_pkg::OUT_FROM_POOL;
        pop_hit_next      = 1'b1;
        cnt_new           = cnt - 1'b1;
        slot              = cnt - 1'b1;
        cnt_we            = 1'b1;
        mem_re            = 1'b1;
      end
    end else begin
      if (cnt > scfl_pkg::COUNT_W'(list_cap)
          || cnt >= scfl_pkg::COUNT_W'(scfl_pkg::STACK_DEPTH)) begin
        // over the cap or full
        pend_next.outcome        = scfl_pkg::OUT_GIVE_BACK;
        pend_next.result_address = req.block_address;
      end else begin
        pend_next.outcome = scfl_pkg::OUT_KEPT;
        cnt_new           = cnt + 1'b1;
        cnt_we            = 1'b1;
        mem_we            = 1'b1;
      end
    end
    if (state != ST_CALC) begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      cnt_we = 1'b0;
    end
  end

  // slot address: class base plus stack position
  assign mem_idx = scfl_pkg::MEM_AW'(cls * scfl_pkg::STACK_DEPTH)
                 + scfl_pkg::MEM_AW'(slot);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slots[mem_idx] <= req.block_address;
    end
    if (mem_re) begin
      rd_data <= slots[mem_idx];
    end
  end

  // popped address comes straight from the memory read port
  always_comb begin
    pend_patched = pend;
    if (pop_hit) begin
      pend_patched.result_address = rd_data;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      smallest  <= scfl_pkg::SMALLEST_RESET;
      list_cap  <= scfl_pkg::CAP_RESET;
      for (int c = 0; c < scfl_pkg::CLASSES; c++) begin
        counts[c] <= '0;
      end
    end else begin
      state <= state_next;
      // configuration writes, expected only while no request is in flight
      if (cfg_write) begin
        if (cfg_index == scfl_pkg::REG_SMALLEST) begin
          smallest <= cfg_data[scfl_pkg::SMALL_W-1:0];
        end else if (cfg_index == scfl_pkg::REG_CAP) begin
          list_cap <= cfg_data[scfl_pkg::CAP_W-1:0];
        end
      end
      if (cnt_we) begin
        counts[cls] <= cnt_new;
      end
      // output register: taken transfer clears, finished result loads
      if (state == ST_READ && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
    if (state == ST_CALC) begin
      pend    <= pend_next;
      pop_hit <= pop_hit_next;
    end
    if (state == ST_READ && out_free) begin
      out_data <= pend_patched;
    end
  end

endmodule
